// File: hw/rtl/sts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// shared types, token kind codes and keyword tables of the sql token scanner
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int KIND_W  = 5;
    localparam int FIELD_W = 16;

    // token kind codes
    localparam logic [KIND_W-1:0] KIND_IDENT    = 5'd0;
    localparam logic [KIND_W-1:0] KIND_NUMBER   = 5'd1;
    localparam logic [KIND_W-1:0] KIND_STRING   = 5'd2;
    localparam logic [KIND_W-1:0] KIND_KEYWORD0 = 5'd3;
    localparam logic [KIND_W-1:0] KIND_OP0      = 5'd13;
    localparam logic [KIND_W-1:0] KIND_INVALID  = 5'd24;
    localparam logic [KIND_W-1:0] KIND_END      = 5'd25;

    // keyword table, text right-justified as literals store it
    localparam int NUM_KEYWORDS = 10;
    localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
        "SELECT", "FROM", "WHERE", "INSERT", "INTO",
        "VALUES", "CREATE", "TABLE", "INT", "VARCHAR"
    };
    localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
        4'd6, 4'd4, 4'd5, 4'd6, 4'd4, 4'd6, 4'd6, 4'd5, 4'd3, 4'd7
    };

    // output beat layout: start and length on tdata, kind on tuser
    localparam int OUT_DATA_W = 32;

    // result queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    // keyword packed with its first character in the lowest byte
    function automatic logic [63:0] kw_packed(int k);
        logic [63:0] p;
        int          n;
        p = '0;
        n = int'(KW_LEN[k]);
        for (int i = 0; i < 8; i++) begin
            if (i < n) begin
                p[8*i +: 8] = KW_TEXT[k][8*(n-1-i) +: 8];
            end
        end
        return p;
    endfunction

endpackage

// File: hw/rtl/sts_keyword_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_keyword_match
// classifies a finished word as one of the ten keywords or an identifier
// ----------------------------------------------------------------------------
module sts_keyword_match
    import sts_pkg::*;
#(
    parameter int POSITION_BITS = 16,
    parameter int KEYWORD_CHARS = 7
) (
    input  logic [8*KEYWORD_CHARS-1:0] i_window,
    input  logic [POSITION_BITS-1:0]   i_len,
    output logic [KIND_W-1:0]          o_kind
);

    logic        short_word;
    logic [63:0] win64;
    logic [3:0]  len4;

    assign short_word = (i_len != '0) && (i_len <= POSITION_BITS'(KEYWORD_CHARS));
    assign win64      = 64'(i_window);
    assign len4       = i_len[3:0];

    // scan downward so the first table entry wins
    always_comb begin
        o_kind = KIND_IDENT;
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
            if (short_word && (len4 == KW_LEN[k]) && (win64 == kw_packed(k))) begin
                o_kind = KIND_KEYWORD0 + KIND_W'(k);
            end
        end
    end

endmodule

// File: hw/rtl/sts_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_result_queue
// small shifting queue that takes up to two token results per cycle
// ----------------------------------------------------------------------------
module sts_result_queue
    import sts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_head,
    input  logic    i_ready
);

    t_result            r_q [QUEUE_DEPTH];
    t_result            n_q [QUEUE_DEPTH];
    logic [QCNT_W-1:0]  r_cnt;
    logic [QCNT_W-1:0]  n_cnt;
    logic [QCNT_W-1:0]  base;
    logic               pop;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_q[0];
    assign o_room  = (r_cnt <= QCNT_W'(QUEUE_DEPTH - 2));
    assign pop     = o_valid && i_ready;
    assign base    = r_cnt - QCNT_W'(pop);
    assign n_cnt   = base + QCNT_W'(i_push.count);

    always_comb begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            n_q[j] = pop ? r_q[(j == QUEUE_DEPTH - 1) ? j : j + 1] : r_q[j];
            if ((i_push.count != 2'd0) && (base == QCNT_W'(j))) begin
                n_q[j] = i_push.first;
            end
            if ((i_push.count == 2'd2) && (base + 1'b1 == QCNT_W'(j))) begin
                n_q[j] = i_push.second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            r_q[j] <= n_q[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: hw/rtl/sql_token_scanner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sql_token_scanner_unit
// byte-at-a-time sql lexer producing one result beat per token
// ----------------------------------------------------------------------------
// Takes one text byte per cycle on the slave side (tuser high marks the end
// of text) and emits token beats on the master side: kind on tuser, start
// offset and length on tdata, with tlast on the final beat caused by an input
// beat. A byte is classified and the scan state updated in the cycle it is
// accepted; its results land in a four-entry result queue and show on the
// master side behind results queued before them. A new byte is taken every
// cycle while the queue has room for two results; the master side drains one
// token per cycle unless stalled, and a byte that both closes a word or number
// and forms an operator yields two results. After an end-of-text beat all
// offsets restart at zero; offsets and lengths saturate at 65535 on the ports.
// ----------------------------------------------------------------------------
module sql_token_scanner_unit
    import sts_pkg::*;
#(
    parameter int POSITION_BITS = 16,
    parameter int KEYWORD_CHARS = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side: text bytes
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] text_byte
    input  logic                  i_s_tuser,   // [0] cmd (1 = end of text)
    // master side: token results
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [15:0] token_start, [31:16] token_length
    output logic [KIND_W-1:0]     o_m_tuser,   // [4:0] token_kind
    output logic                  o_m_tlast    // last
);

    localparam int WIN_W = 8 * KEYWORD_CHARS;
    localparam int EXT_W = (POSITION_BITS > FIELD_W) ? POSITION_BITS : FIELD_W;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // scan modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_WORD   = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;
    localparam logic [1:0] MODE_STRING = 2'd3;

    // clip a position to the 16-bit port fields
    function automatic logic [FIELD_W-1:0] clip_pos(logic [POSITION_BITS-1:0] v);
        logic [EXT_W-1:0] w;
        w = EXT_W'(v);
        return (w > EXT_W'({FIELD_W{1'b1}})) ? {FIELD_W{1'b1}} : w[FIELD_W-1:0];
    endfunction

    // scan state
    logic [1:0]               r_mode,   n_mode;
    logic [POSITION_BITS-1:0] r_pos,    n_pos;
    logic [POSITION_BITS-1:0] r_begin,  n_begin;
    logic [WIN_W-1:0]         r_window, n_window;

    logic       s_acc;
    logic [7:0] c;
    logic       c_alpha, c_digit, c_space, c_under, c_quote, c_word;
    logic [7:0] c_upper;
    logic       op_hit;
    logic [KIND_W-1:0] op_kind;

    logic [POSITION_BITS-1:0] pend_len;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [KIND_W-1:0]        word_kind;

    t_result flush_res, idle_res, end_res, first_res, second_res;
    logic    idle_emit, flush_valid;
    logic    do_flush, take_idle, a_valid, b_valid;
    t_push   push;
    logic    q_room;
    t_result head;

    assign s_acc = i_s_tvalid && o_s_tready;
    assign c     = i_s_tdata;

    // byte classes; anything at 128 and above is in no class and, outside a string, falls through to invalid
    assign c_alpha = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    assign c_digit = (c >= 8'h30) && (c <= 8'h39);
    assign c_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    assign c_under = (c == 8'h5F);
    assign c_quote = (c == 8'h27);
    assign c_word  = c_alpha || c_digit || c_under;
    assign c_upper = ((c >= 8'h61) && (c <= 8'h7A)) ? c - 8'd32 : c;

    // one-character operators, in kind order
    always_comb begin
        op_hit  = 1'b1;
        op_kind = KIND_OP0;
        unique case (c)
            8'h2B:   op_kind = KIND_OP0;          // +
            8'h2D:   op_kind = KIND_OP0 + 5'd1;   // -
            8'h2A:   op_kind = KIND_OP0 + 5'd2;   // *
            8'h2F:   op_kind = KIND_OP0 + 5'd3;   // /
            8'h3D:   op_kind = KIND_OP0 + 5'd4;   // =
            8'h3C:   op_kind = KIND_OP0 + 5'd5;   // <
            8'h3E:   op_kind = KIND_OP0 + 5'd6;   // >
            8'h2C:   op_kind = KIND_OP0 + 5'd7;   // ,
            8'h3B:   op_kind = KIND_OP0 + 5'd8;   // ;
            8'h28:   op_kind = KIND_OP0 + 5'd9;   // (
            8'h29:   op_kind = KIND_OP0 + 5'd10;  // )
            default: op_hit  = 1'b0;
        endcase
    end

    // pending token length, never negative
    assign pend_len = (r_pos >= r_begin) ? r_pos - r_begin : '0;
    assign pos_inc  = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;

    sts_keyword_match #(
        .POSITION_BITS (POSITION_BITS),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_kw_match (
        .i_window (r_window),
        .i_len    (pend_len),
        .o_kind   (word_kind)
    );

    // token that closes the pending word, number or string
    assign flush_valid = (r_mode != MODE_IDLE);
    always_comb begin
        flush_res.kind   = (r_mode == MODE_WORD)   ? word_kind   :
                           (r_mode == MODE_NUMBER) ? KIND_NUMBER : KIND_STRING;
        flush_res.start  = clip_pos(r_begin);
        flush_res.length = clip_pos(pend_len);
        flush_res.last   = 1'b0;
    end

    // single-byte token from a byte seen outside any pending token
    assign idle_emit = !c_space && !c_alpha && !c_under && !c_digit && !c_quote;
    always_comb begin
        idle_res.kind   = op_hit ? op_kind : KIND_INVALID;
        idle_res.start  = clip_pos(r_pos);
        idle_res.length = FIELD_W'(1);
        idle_res.last   = 1'b0;
    end

    always_comb begin
        end_res.kind   = KIND_END;
        end_res.start  = clip_pos(r_pos);
        end_res.length = '0;
        end_res.last   = 1'b0;
    end

    // next scan state and results of the accepted beat
    always_comb begin
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_begin   = r_begin;
        n_window  = r_window;
        do_flush  = 1'b0;
        take_idle = 1'b0;
        if (s_acc) begin
            n_pos = pos_inc;
            if (i_s_tuser) begin
                // end of text: close any pending token, then restart at zero
                do_flush = flush_valid;
                n_mode   = MODE_IDLE;
                n_pos    = '0;
                n_begin  = '0;
                n_window = '0;
            end else begin
                unique case (r_mode)
                    MODE_WORD: begin
                        if (c_word) begin
                            // upper-case copy of the first few characters
                            for (int j = 0; j < KEYWORD_CHARS; j++) begin
                                if (pend_len == POSITION_BITS'(j)) begin
                                    n_window[8*j +: 8] = r_window[8*j +: 8] | c_upper;
                                end
                            end
                        end else begin
                            do_flush  = 1'b1;
                            take_idle = 1'b1;
                        end
                    end
                    MODE_NUMBER: begin
                        if (!c_digit) begin
                            do_flush  = 1'b1;
                            take_idle = 1'b1;
                        end
                    end
                    MODE_STRING: begin
                        // closing quote or nul ends the string, both consumed
                        if (c_quote || (c == 8'h00)) begin
                            do_flush = 1'b1;
                        end
                    end
                    default: begin
                        take_idle = 1'b1;
                    end
                endcase
                if (do_flush) begin
                    n_mode = MODE_IDLE;
                end
                if (take_idle) begin
                    if (c_alpha || c_under) begin
                        n_mode   = MODE_WORD;
                        n_begin  = r_pos;
                        n_window = WIN_W'(c_upper);
                    end else if (c_digit) begin
                        n_mode  = MODE_NUMBER;
                        n_begin = r_pos;
                    end else if (c_quote) begin
                        // string text starts after the opening quote
                        n_mode  = MODE_STRING;
                        n_begin = pos_inc;
                    end
                end
            end
        end
    end

    // order the up to two results: pending token first, then this byte's own
    always_comb begin
        a_valid    = s_acc && do_flush;
        b_valid    = s_acc && (i_s_tuser || (take_idle && idle_emit));
        first_res  = flush_res;
        second_res = i_s_tuser ? end_res : idle_res;
        push.count = 2'd0;
        if (a_valid && b_valid) begin
            push.count      = 2'd2;
            second_res.last = 1'b1;
        end else if (a_valid) begin
            push.count     = 2'd1;
            first_res.last = 1'b1;
        end else if (b_valid) begin
            push.count     = 2'd1;
            first_res      = second_res;
            first_res.last = 1'b1;
        end
        push.first  = first_res;
        push.second = second_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pos    <= '0;
            r_begin  <= '0;
            r_window <= '0;
        end else begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_begin  <= n_begin;
            r_window <= n_window;
        end
    end

    sts_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (q_room),
        .o_valid (o_m_tvalid),
        .o_head  (head),
        .i_ready (i_m_tready)
    );

    assign o_s_tready = q_room;
    assign o_m_tdata  = {head.length, head.start};
    assign o_m_tuser  = head.kind;
    assign o_m_tlast  = head.last;

endmodule

// File: hw/rtl/sts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_checker
// port-level checks of the sql token scanner, bound to the top level
// ----------------------------------------------------------------------------
module sts_checker
    import sts_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [7:0]            i_s_tdata,
    input logic                  i_s_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic [KIND_W-1:0]     o_m_tuser,
    input logic                  o_m_tlast
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result beat changed while stalled");

    // backpressure only while results are queued
    a_stall_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with empty result queue");

    // end token is always the final beat of its input
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_END) |-> o_m_tlast)
        else $error("end token without tlast");

    // operators and invalid bytes are single-byte tokens
    a_single_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser >= KIND_OP0) && (o_m_tuser <= KIND_INVALID)
            |-> (o_m_tdata[31:16] == 16'd1))
        else $error("single-byte token with wrong length");

endmodule

bind sql_token_scanner_unit sts_checker u_sts_checker (.*);
